// ----- design/bitmap_block_allocator_macros.svh -----
// assertion macros shared by the allocator checker
// depends on clk and rst_n being visible where a macro is used
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bba_pkg.sv -----
// shared types, codes and helpers for the bitmap block allocator
// no dependencies
package bba_pkg;

    localparam int MAP_WORDS_DEFAULT = 1024;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_LOAD      = 2'd2,
        CMD_SET_COUNT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_OUT_RANGE = 2'd2
    } status_t;

    localparam logic REG_ALLOC_BASE = 1'b0;
    localparam logic REG_BLK_LIMIT  = 1'b1;

    typedef struct packed {
        status_t     status;
        logic [14:0] block_out;
        logic [15:0] free_count;
    } result_t;

    // index of the lowest set bit, 0 when none
    function automatic logic [4:0] lowest_set(input logic [31:0] bits);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (bits[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- design/bba_map_ram.sv -----
// used/free bitmap storage, one write port and one registered read port
// depends on nothing but its parameters
module bba_map_ram #(
    parameter int WORDS = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- design/bba_ctrl.sv -----
// command sequencer: clearing pass, word scan, read-modify-write, free count
// depends on bba_pkg and drives the ports of bba_map_ram
module bba_ctrl import bba_pkg::*; #(
    parameter int MAP_WORDS = MAP_WORDS_DEFAULT,
    parameter int AW        = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    cmd,
    input  logic [15:0]   block,
    input  logic [9:0]    word_index,
    input  logic [31:0]   word_data,
    input  logic [15:0]   count_value,
    input  logic [15:0]   alloc_base,
    input  logic [15:0]   blk_limit,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [31:0]   mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [31:0]   mem_rdata,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res
);

    localparam int CAP_INT = (MAP_WORDS * 32 < 65535) ? MAP_WORDS * 32 : 65535;
    localparam logic [15:0]   COUNT_CAP = 16'(CAP_INT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FREE  = 6'b001000,
        S_DONE  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [10:0]   cur_reg, cur_next;
    logic [15:0]   blk_reg, blk_next;
    logic [15:0]   free_reg, free_next;
    status_t       stat_reg, stat_next;
    logic [14:0]   got_reg, got_next;

    logic [15:0] tb_m1;
    logic [10:0] first_word;
    logic [10:0] last_word;
    logic [4:0]  lo_sh;
    logic [4:0]  hi_sh;
    logic [31:0] free_bits;
    logic [4:0]  pos;
    logic [15:0] free_inc;
    logic [15:0] free_dec;

    assign tb_m1      = blk_limit - 16'd1;
    assign first_word = alloc_base[15:5];
    assign last_word  = tb_m1[15:5];
    assign lo_sh      = (cur_reg == first_word) ? alloc_base[4:0] : 5'd0;
    assign hi_sh      = (cur_reg == last_word) ? ~tb_m1[4:0] : 5'd0;
    assign free_bits  = ~mem_rdata & (32'hFFFF_FFFF << lo_sh) & (32'hFFFF_FFFF >> hi_sh);
    assign pos        = lowest_set(free_bits);
    assign free_inc   = (free_reg < COUNT_CAP) ? free_reg + 16'd1 : free_reg;
    assign free_dec   = (free_reg != 16'd0) ? free_reg - 16'd1 : free_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        blk_next   = blk_reg;
        free_next  = free_reg;
        stat_next  = stat_reg;
        got_next   = got_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = 32'd0;
        mem_raddr  = AW'(32'(cur_reg));
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    got_next  = 15'd0;
                    stat_next = ST_OK;
                    blk_next  = block;
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            if ((alloc_base >= blk_limit) ||
                                (32'(first_word) >= MAP_WORDS))
                            begin
                                stat_next  = ST_NO_SPACE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cur_next   = first_word;
                                mem_raddr  = AW'(32'(first_word));
                                state_next = S_SCAN;
                            end
                        end
                        CMD_FREE:
                        begin
                            if ((block < alloc_base) || (block >= blk_limit))
                            begin
                                stat_next  = ST_OUT_RANGE;
                                state_next = S_DONE;
                            end
                            else if (32'(block[15:5]) >= MAP_WORDS)
                            begin
                                free_next  = free_inc;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mem_raddr  = AW'(32'(block[15:5]));
                                state_next = S_FREE;
                            end
                        end
                        CMD_LOAD:
                        begin
                            if (32'(word_index) < MAP_WORDS)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(32'(word_index));
                                mem_wdata = word_data;
                            end
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            free_next  = (count_value > COUNT_CAP) ? COUNT_CAP : count_value;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (free_bits != 32'd0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(32'(cur_reg));
                    mem_wdata  = mem_rdata | (32'd1 << pos);
                    got_next   = {cur_reg[9:0], pos};
                    free_next  = free_dec;
                    state_next = S_DONE;
                end
                else if ((cur_reg == last_word) || (32'(cur_reg) + 32'd1 >= MAP_WORDS))
                begin
                    stat_next  = ST_NO_SPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next  = cur_reg + 11'd1;
                    mem_raddr = AW'(32'(cur_reg) + 32'd1);
                end
            end
            S_FREE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(32'(blk_reg[15:5]));
                mem_wdata  = mem_rdata & ~(32'd1 << blk_reg[4:0]);
                free_next  = free_inc;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            free_reg  <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        blk_reg  <= blk_next;
        stat_reg <= stat_next;
        got_reg  <= got_next;
    end

    assign res = '{status: stat_reg, block_out: got_reg, free_count: free_reg};

endmodule

// ----- design/bitmap_block_allocator.sv -----
// top level of the first-fit bitmap block allocator: config registers and result register
// depends on bba_pkg, bba_ctrl and bba_map_ram
// After reset the block clears its bitmap, one word per cycle, and accepts no command until
// done; config writes are taken at any time. Commands run one at a time. Allocate reads one
// bitmap word per cycle from the word holding the first eligible block up to the one holding
// the last block below the limit, the last word of the map or the first word with a free
// eligible block. Each command gives one result; the result register lets the next command
// start while a result waits.
module bitmap_block_allocator import bba_pkg::*; #(
    parameter int MAP_WORDS = MAP_WORDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] block,
    input  logic [9:0]  word_index,
    input  logic [31:0] word_data,
    input  logic [15:0] count_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [14:0] block_out,
    output logic [15:0] free_count
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [15:0] alloc_base_reg;
    logic [15:0] blk_limit_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic          res_valid;
    logic          res_ready;
    result_t       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_base_reg <= 16'd0;
            blk_limit_reg  <= 16'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALLOC_BASE: alloc_base_reg <= cfg_wdata;
                REG_BLK_LIMIT:  blk_limit_reg  <= cfg_wdata;
                default:        alloc_base_reg <= alloc_base_reg;
            endcase
        end
    end

    bba_ctrl #(
        .MAP_WORDS (MAP_WORDS),
        .AW        (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .block        (block),
        .word_index   (word_index),
        .word_data    (word_data),
        .count_value  (count_value),
        .alloc_base   (alloc_base_reg),
        .blk_limit    (blk_limit_reg),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    bba_map_ram #(
        .WORDS (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign block_out  = out_reg.block_out;
    assign free_count = out_reg.free_count;

endmodule

// ----- design/bba_checker.sv -----
// port-level checks for the bitmap block allocator, bound to the top level
// depends on bba_pkg and bitmap_block_allocator_macros.svh
`include "bitmap_block_allocator_macros.svh"

module bba_checker import bba_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [14:0] block_out,
    input logic [15:0] free_count
);

    logic        out_stall;
    logic        fail_out;
    logic [32:0] out_bus;

    assign out_stall = out_valid && !out_ready;
    assign fail_out  = out_valid && (status != ST_OK);
    assign out_bus   = {status, block_out, free_count};

    // a stalled result holds
    `BBA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_bus), "stalled result changed")

    // one command at a time
    `BBA_ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready, "command taken while busy")

    // failed results carry block zero
    `BBA_ASSERT_NOW(a_fail_block, fail_out, block_out == 15'd0, "block set on failure")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
